/* sv/sccb_register_master_unit_defines.svh */
// Assertion macros shared by the checker file of the SCCB register master.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef SCCB_REGISTER_MASTER_UNIT_DEFINES_SVH
`define SCCB_REGISTER_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SCCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sccb check failed");

// Next-cycle implication, disabled while in reset
`define SCCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sccb check failed");

`endif

/* sv/sccb_pkg.sv */
// Types and constants of the SCCB register master.
// No dependencies; imported by every module of the block.
package sccb_pkg;

    // Acknowledge slot gives up after this many high samples
    localparam logic [7:0] ACK_TIMEOUT = 8'd200;
    // Read bit of the device address
    localparam logic [7:0] READ_BIT    = 8'h01;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register map, index is paddr[2]
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_PHASE_TICKS    = 1'b1;

    // Raw command codes on the input
    localparam logic [1:0] CMD_CODE_WRITE = 2'd1;
    localparam logic [1:0] CMD_CODE_READ  = 2'd2;

    // Reset values of the registers
    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd96;
    localparam logic [7:0] PHASE_TICKS_RST    = 8'd10;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_WRITE,
        KIND_READ
    } cmd_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_HI,
        PH_START_LO,
        PH_SEND,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_RECV,
        PH_NACK_LO,
        PH_NACK_HI,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } phase_t;

    typedef enum logic [2:0] {
        ST_DEV_W,
        ST_REG,
        ST_DATA,
        ST_MID_STOP,
        ST_DEV_R,
        ST_RECV,
        ST_FINAL
    } stage_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } sccb_in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } sccb_out_t;

    // Classified item as held in the queue
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } sccb_entry_t;

endpackage

/* sv/sccb_register_master_unit.sv */
// Top level of the SCCB register master: register port, front end, queue, engine.
// Depends on sccb_pkg, sccb_front, sccb_queue and sccb_engine.
//
//   channel   signals                        direction   item
//   cmd       cmd_valid / cmd_stall          in          sccb_in_t, one bus tick
//   res       res_valid / res_stall          out         sccb_out_t, one per tick
//   apb       psel penable pwrite paddr ...  in/out      device_address, phase_ticks
//
// One item per cycle sustained while results are not stalled; the engine does one bus tick per cycle.
// A result passes the queue write, then the engine step into the output register.
// The queue holds four items; cmd_stall rises only when it is full.
// A stalled result holds in the output register while the queue keeps filling.
// Reset clears sequencer and queue and loads the register reset values at once; no clearing pass.
module sccb_register_master_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sccb_pkg::sccb_in_t  cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output sccb_pkg::sccb_out_t res_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sccb_pkg::*;

    logic [7:0]  device_address_reg;
    logic [7:0]  phase_ticks_reg;
    logic        cfg_write;

    logic        push;
    sccb_entry_t push_entry;
    logic        queue_full;
    logic        pop;
    sccb_entry_t head;
    logic        head_valid;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RST;
            phase_ticks_reg    <= PHASE_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_DEVICE_ADDRESS: device_address_reg <= pwdata[7:0];
                REG_PHASE_TICKS:    phase_ticks_reg    <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DEVICE_ADDRESS: prdata = {24'd0, device_address_reg};
            REG_PHASE_TICKS:    prdata = {24'd0, phase_ticks_reg};
        endcase
    end

    sccb_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    sccb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    sccb_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .device_address (device_address_reg),
        .phase_ticks    (phase_ticks_reg),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item)
    );

endmodule

/* sv/sccb_front.sv */
// Front end: accepts tick items and classifies the command code.
// Depends on sccb_pkg; feeds sccb_queue.
module sccb_front (
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  sccb_pkg::sccb_in_t   cmd_item,
    input  logic                 queue_full,
    output logic                 push,
    output sccb_pkg::sccb_entry_t push_entry
);
    import sccb_pkg::*;

    // Code 3 and 0 are plain ticks
    always_comb
    begin
        unique case (cmd_item.cmd)
            CMD_CODE_WRITE: push_entry.kind = KIND_WRITE;
            CMD_CODE_READ:  push_entry.kind = KIND_READ;
            default:        push_entry.kind = KIND_TICK;
        endcase
        push_entry.reg_addr   = cmd_item.reg_addr;
        push_entry.write_data = cmd_item.write_data;
        push_entry.sda_in     = cmd_item.sda_in;
    end

    assign cmd_stall = queue_full;
    assign push      = cmd_valid && !queue_full;

endmodule

/* sv/sccb_queue.sv */
// Short item queue between the front end and the bus engine.
// Depends on sccb_pkg for the entry type and depth.
module sccb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sccb_pkg::sccb_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output sccb_pkg::sccb_entry_t head,
    output logic                  head_valid
);
    import sccb_pkg::*;

    sccb_entry_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg, count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

/* sv/sccb_engine.sv */
// Back end: SCCB bus sequencer, one tick per queued item, with result register.
// Depends on sccb_pkg; fed by sccb_queue.
module sccb_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sccb_pkg::sccb_entry_t head,
    input  logic                  head_valid,
    output logic                  pop,
    input  logic [7:0]            device_address,
    input  logic [7:0]            phase_ticks,
    output logic                  res_valid,
    input  logic                  res_stall,
    output sccb_pkg::sccb_out_t   res_item
);
    import sccb_pkg::*;

    phase_t     phase_reg, phase_next;
    stage_t     stage_reg, stage_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] ack_wait_reg, ack_wait_next;
    logic [7:0] held_register_reg, held_register_next;
    logic [7:0] held_data_reg, held_data_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] received_reg, received_next;
    logic       error_reg, error_next;
    logic       done_next;

    logic       res_valid_reg, res_valid_next;
    sccb_out_t  res_item_reg, res_item_next;

    logic       step_en;
    logic [7:0] hold;
    logic       elapsed;
    logic [2:0] bit_idx;
    logic       scl, lvl, drv;

    // One tick per cycle while an item is queued and the result register can take it
    assign step_en = head_valid && (!res_valid_reg || !res_stall);
    assign pop     = step_en;

    assign hold    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    assign elapsed = ({1'b0, tick_count_reg} + 9'd1) >= {1'b0, hold};
    assign bit_idx = 3'd7 - bit_count_reg[3:1];

    // Pin levels from the current phase
    always_comb
    begin
        scl = 1'b1;
        lvl = 1'b1;
        drv = 1'b0;
        unique case (phase_reg)
            PH_START_HI: drv = 1'b1;
            PH_START_LO:
            begin
                lvl = 1'b0;
                drv = 1'b1;
            end
            PH_SEND:
            begin
                scl = bit_count_reg[0];
                lvl = shift_byte_reg[bit_idx];
                drv = 1'b1;
            end
            PH_ACK_LO:  scl = 1'b0;
            PH_ACK_HI:  scl = 1'b1;
            PH_RECV:    scl = bit_count_reg[0];
            PH_NACK_LO:
            begin
                scl = 1'b0;
                drv = 1'b1;
            end
            PH_NACK_HI: drv = 1'b1;
            PH_STOP_A:
            begin
                scl = 1'b0;
                lvl = 1'b0;
                drv = 1'b1;
            end
            PH_STOP_B:
            begin
                lvl = 1'b0;
                drv = 1'b1;
            end
            PH_STOP_C:  drv = 1'b1;
            default:    ;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        phase_next         = phase_reg;
        stage_next         = stage_reg;
        bit_count_next     = bit_count_reg;
        shift_byte_next    = shift_byte_reg;
        tick_count_next    = tick_count_reg;
        ack_wait_next      = ack_wait_reg;
        held_register_next = held_register_reg;
        held_data_next     = held_data_reg;
        is_read_next       = is_read_reg;
        received_next      = received_reg;
        error_next         = error_reg;
        done_next          = 1'b0;

        priority if (phase_reg == PH_IDLE)
        begin
            // New command latches its operands
            if (head.kind != KIND_TICK)
            begin
                held_register_next = head.reg_addr;
                held_data_next     = head.write_data;
                is_read_next       = (head.kind == KIND_READ);
                error_next         = 1'b0;
                stage_next         = ST_DEV_W;
                tick_count_next    = 8'd0;
                phase_next         = PH_START_HI;
            end
        end
        else if (phase_reg == PH_ACK_HI)
        begin
            // Acknowledge slot: wait out the phase, then sample every tick
            priority if (!elapsed)
            begin
                tick_count_next = tick_count_reg + 8'd1;
            end
            else if (!head.sda_in)
            begin
                tick_count_next = 8'd0;
                unique case (stage_reg)
                    ST_DEV_W:
                    begin
                        stage_next      = ST_REG;
                        shift_byte_next = held_register_reg;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_SEND;
                    end
                    ST_REG:
                    begin
                        if (is_read_reg)
                        begin
                            stage_next = ST_MID_STOP;
                            phase_next = PH_STOP_A;
                        end
                        else
                        begin
                            stage_next      = ST_DATA;
                            shift_byte_next = held_data_reg;
                            bit_count_next  = 4'd0;
                            phase_next      = PH_SEND;
                        end
                    end
                    ST_DEV_R:
                    begin
                        stage_next      = ST_RECV;
                        shift_byte_next = 8'd0;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_RECV;
                    end
                    default:
                    begin
                        stage_next = ST_FINAL;
                        phase_next = PH_STOP_A;
                    end
                endcase
            end
            else
            begin
                ack_wait_next = ack_wait_reg + 8'd1;
                if (ack_wait_next >= ACK_TIMEOUT)
                begin
                    error_next      = 1'b1;
                    tick_count_next = 8'd0;
                    stage_next      = ST_FINAL;
                    phase_next      = PH_STOP_A;
                end
            end
        end
        else if (!elapsed)
        begin
            tick_count_next = tick_count_reg + 8'd1;
        end
        else
        begin
            // Phase time is up: move to the next pin step
            tick_count_next = 8'd0;
            unique case (phase_reg)
                PH_START_HI: phase_next = PH_START_LO;
                PH_START_LO:
                begin
                    shift_byte_next = (stage_reg == ST_DEV_R) ?
                                      (device_address | READ_BIT) : device_address;
                    bit_count_next  = 4'd0;
                    phase_next      = PH_SEND;
                end
                PH_SEND:
                begin
                    if (bit_count_reg != 4'd15)
                        bit_count_next = bit_count_reg + 4'd1;
                    else
                        phase_next = PH_ACK_LO;
                end
                PH_ACK_LO:
                begin
                    ack_wait_next = 8'd0;
                    phase_next    = PH_ACK_HI;
                end
                PH_RECV:
                begin
                    // Sample on the clock-high half of each bit
                    if (bit_count_reg[0])
                        shift_byte_next = {shift_byte_reg[6:0], head.sda_in};
                    if (bit_count_reg != 4'd15)
                        bit_count_next = bit_count_reg + 4'd1;
                    else
                    begin
                        received_next = shift_byte_next;
                        phase_next    = PH_NACK_LO;
                    end
                end
                PH_NACK_LO:  phase_next = PH_NACK_HI;
                PH_NACK_HI:
                begin
                    stage_next = ST_FINAL;
                    phase_next = PH_STOP_A;
                end
                PH_STOP_A:   phase_next = PH_STOP_B;
                PH_STOP_B:   phase_next = PH_STOP_C;
                PH_STOP_C:
                begin
                    // Mid-read stop restarts for the read phase
                    if (stage_reg == ST_MID_STOP && is_read_reg && !error_reg)
                    begin
                        stage_next = ST_DEV_R;
                        phase_next = PH_START_HI;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default:     phase_next = PH_IDLE;
            endcase
        end
    end

    // Result assembly and output register control
    always_comb
    begin
        res_item_next.scl_level = scl;
        res_item_next.sda_level = lvl;
        res_item_next.sda_drive = drv;
        res_item_next.busy_res  = (phase_next != PH_IDLE);
        res_item_next.done_res  = done_next;
        res_item_next.read_data = received_next;
        res_item_next.ack_error = error_next;

        if (step_en)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            stage_reg         <= ST_DEV_W;
            bit_count_reg     <= '0;
            shift_byte_reg    <= '0;
            tick_count_reg    <= '0;
            ack_wait_reg      <= '0;
            held_register_reg <= '0;
            held_data_reg     <= '0;
            is_read_reg       <= 1'b0;
            received_reg      <= '0;
            error_reg         <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            stage_reg         <= stage_next;
            bit_count_reg     <= bit_count_next;
            shift_byte_reg    <= shift_byte_next;
            tick_count_reg    <= tick_count_next;
            ack_wait_reg      <= ack_wait_next;
            held_register_reg <= held_register_next;
            held_data_reg     <= held_data_next;
            is_read_reg       <= is_read_next;
            received_reg      <= received_next;
            error_reg         <= error_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

/* sv/sccb_checker.sv */
// Port-level checks of the SCCB register master, bound to the top level.
// Depends on sccb_pkg and sccb_register_master_unit_defines.svh.
`include "sccb_register_master_unit_defines.svh"

module sccb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input sccb_pkg::sccb_out_t res_item,
    input logic                psel,
    input logic                pready
);
    import sccb_pkg::*;

    // A stalled result stays offered and unchanged
    `SCCB_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
    `SCCB_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_item))

    // Finishing tick leaves the block idle
    `SCCB_ASSERT_NOW(a_done_not_busy, res_valid && res_item.done_res, !res_item.busy_res)

    // Released data line reports a high level
    `SCCB_ASSERT_NOW(a_release_high, res_valid && !res_item.sda_drive, res_item.sda_level)

    // Register port never waits
    `SCCB_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind sccb_register_master_unit sccb_checker u_sccb_checker (.*);
